// ===== hw/rtl/ifs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared types, widths and constants of the frame statistics block.
// ----------------------------------------------------------------------------
package ifs_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int RUN_W   = 9;
  localparam int ROWS_W  = 9;
  localparam int CNT_W   = 18;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 10;
  localparam int FW_W    = 10;
  localparam int FH_W    = 9;

  // Saturation limits
  localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
  localparam logic [ROWS_W-1:0] ROWS_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // Reset values of the registers
  localparam int WIDTH_RST  = 320;
  localparam int HEIGHT_RST = 200;
  localparam logic [PIX_W-1:0] THRESH_RST = 8'd128;

  // Register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } ifs_reg_e;

  // Settings seen by the datapath
  typedef struct packed {
    logic [COL_W-1:0] wlast;   // last column index
    logic [ROW_W-1:0] hlast;   // last row index
    logic [PIX_W-1:0] thresh;  // contrast threshold
  } ifs_cfg_t;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== hw/rtl/ifs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ifs_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first on an address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ifs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_cfg
// Configuration registers: clamps frame size and flags a frame restart.
// ----------------------------------------------------------------------------
module ifs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ifs_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [ifs_pkg::CDATA_W-1:0]   cfg_data_i,
  output ifs_pkg::ifs_cfg_t             cfg_o,
  output logic                          restart_o
);

  ifs_pkg::ifs_cfg_t cfg_q, cfg_d;
  logic              restart;
  int unsigned       wv;
  int unsigned       hv;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    wv = 32'(cfg_data_i[ifs_pkg::FW_W-1:0]);
    hv = 32'(cfg_data_i[ifs_pkg::FH_W-1:0]);
    if (wv < 2) wv = 2;
    if (wv > ifs_pkg::MAX_WIDTH) wv = ifs_pkg::MAX_WIDTH;
    if (hv < 1) hv = 1;
    if (hv > ifs_pkg::MAX_HEIGHT) hv = ifs_pkg::MAX_HEIGHT;

    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ifs_pkg::REG_WIDTH: begin
          cfg_d.wlast = ifs_pkg::COL_W'(wv - 1);
          restart     = 1'b1;
        end
        ifs_pkg::REG_HEIGHT: begin
          cfg_d.hlast = ifs_pkg::ROW_W'(hv - 1);
          restart     = 1'b1;
        end
        ifs_pkg::REG_THRESH: begin
          cfg_d.thresh = cfg_data_i[ifs_pkg::PIX_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wlast  <= ifs_pkg::COL_W'(ifs_pkg::WIDTH_RST - 1);
      cfg_q.hlast  <= ifs_pkg::ROW_W'(ifs_pkg::HEIGHT_RST - 1);
      cfg_q.thresh <= ifs_pkg::THRESH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign restart_o = restart;

endmodule

// ===== hw/rtl/image_frame_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_frame_statistics
// Per-frame contrast, symmetry and vertical run statistics of a pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one word per clock, and are fully processed
// in the cycle they are accepted. The line memories are read ahead
// at the next column, so their registered read data is ready when the pixel
// arrives; a write followed at once by a read of the same entry is forwarded.
// With the last pixel of a frame the result word (brightest, darkest,
// asymmetric rows, contrast pixels, longest vertical run) is loaded into an
// output register and the statistics restart. The output register lets the
// next frame start while a result still waits; s_axis_tready drops only when
// a result is held and the sink does not take it. Sustained rate: 1 pixel
// per clock unless stalled; the result is valid the cycle after the last
// pixel. Writing the width or height restarts the frame; the threshold
// applies from the next pixel. Line memories need no clearing after reset.
// ----------------------------------------------------------------------------
module image_frame_statistics (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel stream; tdata: [7:0] pixel
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,
  // result stream; tdata: [7:0] brightest, [15:8] darkest,
  // [24:16] asymmetric_rows, [42:25] contrast_pixels,
  // [51:43] longest_vertical_run, [55:52] zero
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [55:0]                 m_axis_tdata,
  // register writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ifs_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [ifs_pkg::CDATA_W-1:0] cfg_data_i
);

  localparam int COL_W  = ifs_pkg::COL_W;
  localparam int ROW_W  = ifs_pkg::ROW_W;
  localparam int PIX_W  = ifs_pkg::PIX_W;
  localparam int RUN_W  = ifs_pkg::RUN_W;
  localparam int ROWS_W = ifs_pkg::ROWS_W;
  localparam int CNT_W  = ifs_pkg::CNT_W;

  ifs_pkg::ifs_cfg_t cfg;
  logic              restart;

  ifs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .restart_o   (restart)
  );

  // --------------------------------------------------------------------------
  // Frame position and running statistics
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [PIX_W-1:0]  left_pix_q, left_pix_d;
  logic              left_flag_q, left_flag_d;
  logic              tail_flag_q, tail_flag_d;   // flag of the last column
  logic              mism_q, mism_d;             // current row not mirrored
  logic [PIX_W-1:0]  max_q, max_d;
  logic [PIX_W-1:0]  min_q, min_d;
  logic [ROWS_W-1:0] rows_q, rows_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RUN_W-1:0]  best_q, best_d;

  // forwarding of a write that the next read hits
  logic              mir_fwd_q, mir_fwd_d;
  logic [PIX_W-1:0]  mir_fwd_pix_q;
  logic              fl_fwd_q, fl_fwd_d;
  logic              fl_fwd_bit_q;

  // result register
  logic              res_valid_q, res_valid_d;
  logic [PIX_W-1:0]  res_max_q, res_min_q;
  logic [ROWS_W-1:0] res_rows_q;
  logic [CNT_W-1:0]  res_cnt_q;
  logic [RUN_W-1:0]  res_best_q;

  // memory ports
  logic [PIX_W-1:0]  above_rd, mir_rd;
  logic [RUN_W-1:0]  run_rd, run_new;
  logic              fl_rd;
  logic [COL_W-1:0]  mir_raddr;
  logic              fl_we;
  logic [COL_W-1:0]  fl_waddr;
  logic              fl_wdata;

  // per-pixel terms
  logic              acc, frame_end;
  logic [PIX_W-1:0]  pix;
  logic              first_row, last_row, last_col;
  logic              vdiff, hdiff, cur_flag, lf, flag_above;
  logic [PIX_W-1:0]  mir_pix;
  logic [COL_W-1:0]  mir_col;
  logic              row_diff;
  logic [1:0]        cnt_inc;
  logic [CNT_W:0]    cnt_sum;
  logic [PIX_W-1:0]  max_n, min_n;
  logic [ROWS_W-1:0] rows_n;
  logic [CNT_W-1:0]  cnt_n;
  logic [RUN_W-1:0]  best_n;

  assign s_axis_tready = !res_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign pix           = s_axis_tdata;

  assign first_row = (row_q == '0);
  assign last_row  = (row_q == cfg.hlast);
  assign last_col  = (col_q == cfg.wlast);
  assign frame_end = acc && last_col && last_row;

  // Contrast: vertical against the pixel above, horizontal against the left.
  assign vdiff    = !first_row && (ifs_pkg::abs_diff(pix, above_rd) > cfg.thresh);
  assign hdiff    = (col_q != '0) && (ifs_pkg::abs_diff(pix, left_pix_q) > cfg.thresh);
  assign cur_flag = hdiff || vdiff;
  assign lf       = left_flag_q || hdiff;  // left pixel now has its right side

  // flag of the pixel above; the last column lives in its own register
  assign flag_above = last_col ? tail_flag_q : (fl_fwd_q ? fl_fwd_bit_q : fl_rd);

  // Vertical runs: one more when equal to the pixel above, else restart.
  always_comb begin
    if (!first_row && (pix == above_rd)) begin
      run_new = (run_rd < ifs_pkg::RUN_MAX) ? (run_rd + 1'b1) : run_rd;
    end else begin
      run_new = RUN_W'(1);
    end
  end

  // Mirror check against the already stored left half of this row.
  assign mir_col  = cfg.wlast - col_q;
  assign mir_pix  = mir_fwd_q ? mir_fwd_pix_q : mir_rd;
  assign row_diff = (mir_col < col_q) && (mir_pix != pix);

  // Up to three pixels finish their contrast check with this one.
  assign cnt_inc = 2'((!first_row && (flag_above || vdiff)))
                 + 2'(((col_q != '0) && last_row && lf))
                 + 2'((last_col && last_row && cur_flag));
  assign cnt_sum = {1'b0, cnt_q} + (CNT_W+1)'(cnt_inc);

  always_comb begin
    max_n  = (pix > max_q) ? pix : max_q;
    min_n  = (pix < min_q) ? pix : min_q;
    cnt_n  = (cnt_sum > {1'b0, ifs_pkg::CNT_MAX}) ? ifs_pkg::CNT_MAX : cnt_sum[CNT_W-1:0];
    best_n = (run_new > best_q) ? run_new : best_q;
    rows_n = rows_q;
    if (last_col && (mism_q || row_diff) && (rows_q < ifs_pkg::ROWS_MAX)) begin
      rows_n = rows_q + 1'b1;
    end
  end

  // Flag memory: a pixel's flag is final once its right neighbor is seen.
  assign fl_we    = acc && (col_q != '0);
  assign fl_waddr = col_q - 1'b1;
  assign fl_wdata = lf;

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    left_pix_d  = left_pix_q;
    left_flag_d = left_flag_q;
    tail_flag_d = tail_flag_q;
    mism_d      = mism_q;
    max_d       = max_q;
    min_d       = min_q;
    rows_d      = rows_q;
    cnt_d       = cnt_q;
    best_d      = best_q;
    res_valid_d = res_valid_q && !m_axis_tready;

    if (restart) begin
      col_d       = '0;
      row_d       = '0;
      left_pix_d  = '0;
      left_flag_d = 1'b0;
      mism_d      = 1'b0;
      max_d       = '0;
      min_d       = '1;
      rows_d      = '0;
      cnt_d       = '0;
      best_d      = RUN_W'(1);
    end else if (acc) begin
      max_d  = max_n;
      min_d  = min_n;
      cnt_d  = cnt_n;
      best_d = best_n;
      rows_d = rows_n;
      if (last_col) begin
        tail_flag_d = cur_flag;
        col_d       = '0;
        left_pix_d  = '0;
        left_flag_d = 1'b0;
        mism_d      = 1'b0;
        row_d       = last_row ? '0 : (row_q + 1'b1);
      end else begin
        col_d       = col_q + 1'b1;
        left_pix_d  = pix;
        left_flag_d = cur_flag;
        mism_d      = mism_q || row_diff;
      end
      if (last_col && last_row) begin
        // hand over the frame and start the next one
        res_valid_d = 1'b1;
        max_d       = '0;
        min_d       = '1;
        rows_d      = '0;
        cnt_d       = '0;
        best_d      = RUN_W'(1);
      end
    end
  end

  // reads are issued for the column that comes next
  assign mir_raddr = cfg.wlast - col_d;
  assign mir_fwd_d = acc && (col_q == mir_raddr);
  assign fl_fwd_d  = fl_we && (fl_waddr == col_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_pix_q  <= '0;
      left_flag_q <= 1'b0;
      tail_flag_q <= 1'b0;
      mism_q      <= 1'b0;
      max_q       <= '0;
      min_q       <= '1;
      rows_q      <= '0;
      cnt_q       <= '0;
      best_q      <= RUN_W'(1);
      mir_fwd_q   <= 1'b0;
      fl_fwd_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      left_pix_q  <= left_pix_d;
      left_flag_q <= left_flag_d;
      tail_flag_q <= tail_flag_d;
      mism_q      <= mism_d;
      max_q       <= max_d;
      min_q       <= min_d;
      rows_q      <= rows_d;
      cnt_q       <= cnt_d;
      best_q      <= best_d;
      mir_fwd_q   <= mir_fwd_d;
      fl_fwd_q    <= fl_fwd_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mir_fwd_pix_q <= pix;
    fl_fwd_bit_q  <= fl_wdata;
    if (frame_end) begin
      res_max_q  <= max_n;
      res_min_q  <= min_n;
      res_rows_q <= rows_n;
      res_cnt_q  <= cnt_n;
      res_best_q <= best_n;
    end
  end

  // --------------------------------------------------------------------------
  // Line memories
  // --------------------------------------------------------------------------
  // Two copies of the pixel line: one read above the next pixel, one at
  // its mirror position.
  ifs_ram #(.Width(PIX_W), .Depth(ifs_pkg::MAX_WIDTH)) u_line_above (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (col_q),
    .wdata_i (pix),
    .raddr_i (col_d),
    .rdata_o (above_rd)
  );

  ifs_ram #(.Width(PIX_W), .Depth(ifs_pkg::MAX_WIDTH)) u_line_mirror (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (col_q),
    .wdata_i (pix),
    .raddr_i (mir_raddr),
    .rdata_o (mir_rd)
  );

  ifs_ram #(.Width(1), .Depth(ifs_pkg::MAX_WIDTH)) u_flags (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (col_d),
    .rdata_o (fl_rd)
  );

  ifs_ram #(.Width(RUN_W), .Depth(ifs_pkg::MAX_WIDTH)) u_runs (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (col_q),
    .wdata_i (run_new),
    .raddr_i (col_d),
    .rdata_o (run_rd)
  );

  // --------------------------------------------------------------------------
  // Result stream
  // --------------------------------------------------------------------------
  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {4'b0, res_best_q, res_cnt_q, res_rows_q, res_min_q, res_max_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_col_in_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= cfg.wlast)
    else $error("column index past end of row");

  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end && !restart |=> (col_q == '0) && (row_q == '0) && res_valid_q)
    else $error("frame end did not restart and post a result");

  a_dark_le_bright : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_min_q <= res_max_q) && (res_best_q != '0))
    else $error("inconsistent result word");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !m_axis_tready |-> !frame_end)
    else $error("result overwritten while held");

endmodule

// ===== sim/frame_stats_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stats_checker
// Watches the pixel, result and register channels of the frame statistics
// block, predicts each frame result and compares it field by field.
// ----------------------------------------------------------------------------
module frame_stats_checker
  import ifs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [55:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CIDX_W-1:0]  cfg_index_i,
  input  logic [CDATA_W-1:0] cfg_data_i,
  output int                 fail_count_o,
  output int                 outstanding_o
);

  // result word, first field in the low bits
  typedef struct packed {
    logic [3:0]        pad;
    logic [RUN_W-1:0]  longest_run;
    logic [CNT_W-1:0]  contrast_px;
    logic [ROWS_W-1:0] asym_rows;
    logic [PIX_W-1:0]  darkest;
    logic [PIX_W-1:0]  brightest;
  } frame_stats_t;

  frame_stats_t stats_q[$];
  frame_stats_t want;
  frame_stats_t got;

  // registers as the block should hold them
  logic [FW_W-1:0]  width_q;
  logic [FH_W-1:0]  height_q;
  logic [PIX_W-1:0] thresh_q;

  // shadow of the block's frame state
  logic [PIX_W-1:0]  line_mem [MAX_WIDTH];
  logic              flag_mem [MAX_WIDTH];
  logic [RUN_W-1:0]  run_mem  [MAX_WIDTH];
  logic [PIX_W-1:0]  left_pix;
  logic              left_flag;
  int unsigned       col;
  int unsigned       row;
  logic              row_diff;
  logic [PIX_W-1:0]  hi_pix;
  logic [PIX_W-1:0]  lo_pix;
  logic [ROWS_W-1:0] asym_cnt;
  logic [CNT_W-1:0]  contrast_cnt;
  logic [RUN_W-1:0]  best_run;
  int                k;

  function automatic int unsigned used_width();
    if (width_q < 2) return 2;
    if (width_q > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_q);
  endfunction

  function automatic int unsigned used_height();
    if (height_q < 1) return 1;
    if (height_q > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(height_q);
  endfunction

  function automatic logic [PIX_W-1:0] pix_dist(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic clear_frame();
    for (k = 0; k < MAX_WIDTH; k++) begin
      flag_mem[k] = 1'b0;
      run_mem[k]  = RUN_W'(1);
    end
    left_pix     = '0;
    left_flag    = 1'b0;
    col          = 0;
    row          = 0;
    row_diff     = 1'b0;
    hi_pix       = '0;
    lo_pix       = '1;
    asym_cnt     = '0;
    contrast_cnt = '0;
    best_run     = RUN_W'(1);
  endtask

  task automatic bump_contrast(input logic hit);
    if (hit && contrast_cnt != CNT_MAX) contrast_cnt++;
  endtask

  // one accepted pixel; queues a result with the last pixel of a frame
  task automatic take_pixel(input logic [PIX_W-1:0] p);
    int unsigned w, h, c, r, m;
    logic [PIX_W-1:0] up;
    logic vd, hd, cur, lf, last_r, last_c;
    frame_stats_t res;
    w = used_width();
    h = used_height();
    c = col;
    r = row;
    last_r = (r == h - 1);
    last_c = (c == w - 1);
    up = line_mem[c];
    vd = (r > 0) && (pix_dist(p, up) > thresh_q);
    hd = (c > 0) && (pix_dist(p, left_pix) > thresh_q);
    // pixel above is settled once its lower neighbour is seen
    if (r > 0) bump_contrast(flag_mem[c] | vd);
    cur = hd | vd;
    if (c > 0) begin
      lf = left_flag | hd;
      flag_mem[c-1] = lf;
      if (last_r) bump_contrast(lf);
    end
    if (last_c) begin
      flag_mem[c] = cur;
      if (last_r) bump_contrast(cur);
    end
    left_flag = cur;
    left_pix  = p;
    if (r > 0 && p == up) begin
      if (run_mem[c] != RUN_MAX) run_mem[c] = run_mem[c] + 1'b1;
    end else begin
      run_mem[c] = RUN_W'(1);
    end
    if (run_mem[c] > best_run) best_run = run_mem[c];
    m = w - 1 - c;
    if (m < c && line_mem[m] != p) row_diff = 1'b1;
    line_mem[c] = p;
    if (p > hi_pix) hi_pix = p;
    if (p < lo_pix) lo_pix = p;
    if (!last_c) begin
      col = c + 1;
    end else begin
      if (row_diff && asym_cnt != ROWS_MAX) asym_cnt++;
      row_diff  = 1'b0;
      col       = 0;
      left_flag = 1'b0;
      left_pix  = '0;
      if (!last_r) begin
        row = r + 1;
      end else begin
        res.pad         = '0;
        res.longest_run = best_run;
        res.contrast_px = contrast_cnt;
        res.asym_rows   = asym_cnt;
        res.darkest     = lo_pix;
        res.brightest   = hi_pix;
        stats_q.push_back(res);
        clear_frame();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] want_v,
                             input logic [CNT_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = FW_W'(WIDTH_RST);
      height_q = FH_W'(HEIGHT_RST);
      thresh_q = THRESH_RST;
      for (k = 0; k < MAX_WIDTH; k++) line_mem[k] = '0;
      clear_frame();
      stats_q.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (stats_q.size() == 0) begin
          $display("%0t: result word with no frame pending, expected none, actual %h",
                   $time, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = stats_q.pop_front();
          check_field("brightest", CNT_W'(want.brightest), CNT_W'(got.brightest));
          check_field("darkest", CNT_W'(want.darkest), CNT_W'(got.darkest));
          check_field("asymmetric_rows", CNT_W'(want.asym_rows), CNT_W'(got.asym_rows));
          check_field("contrast_pixels", want.contrast_px, got.contrast_px);
          check_field("longest_vertical_run", CNT_W'(want.longest_run),
                      CNT_W'(got.longest_run));
          check_field("pad bits", CNT_W'(want.pad), CNT_W'(got.pad));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_WIDTH: begin
            width_q = cfg_data_i;
            clear_frame();
          end
          REG_HEIGHT: begin
            height_q = cfg_data_i[FH_W-1:0];
            clear_frame();
          end
          REG_THRESH: thresh_q = cfg_data_i[PIX_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata);
      outstanding_o = stats_q.size();
    end
  end

endmodule

// ===== sim/tb_image_frame_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_frame_statistics
// Drives frames of pixels and register writes into the frame statistics
// block; a checker beside it predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_image_frame_statistics;
  import ifs_pkg::*;

  localparam int     CLK_HALF    = 2;
  localparam int     RST_CYCLES  = 8;
  localparam int     DRAIN       = 4;     // margin after the last result word
  localparam int     LONG_STALL  = 200;   // sink hold-off, long enough to back up the input
  localparam int     RAND_PIXELS = 300;
  localparam int     RAND_FRAMES = 12;
  localparam longint LIMIT       = 1000000;

  // index with no register behind it; the block must ignore the write
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    STY_NOISE,   // full-range random pixels
    STY_LEVELS,  // two grey levels: equal vertical runs and sharp edges
    STY_MIRROR,  // left-right mirrored rows, some broken at the last column
    STY_FLAT     // one grey value with rare flips
  } frame_style_e;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;   // [7:0] pixel
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [55:0]        m_axis_tdata;   // brightest, darkest, asym rows, contrast, run
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_data;

  int     fail_count;
  int     outstanding;
  longint cycle_cnt = 0;

  // stimulus bookkeeping: frame geometry the block should be using
  int               cur_w = WIDTH_RST;
  int               cur_h = HEIGHT_RST;
  logic [CDATA_W-1:0] raw_w = CDATA_W'(WIDTH_RST);
  logic [7:0]       row_pix [MAX_WIDTH];
  int               pix_count = 0;
  int               frames_done = 0;
  bit               quiet = 1'b0;          // no random gaps on either side
  bit               long_stall_req = 1'b0; // request one long sink hold-off (LONG_STALL)

  // random phase locals
  int                 pix_start, frames_start, n_frames, f, sel, cut, thr, j;
  logic [CDATA_W-1:0] wv, hv, tv;
  frame_style_e       sty;

  image_frame_statistics DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  frame_stats_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Result sink. Each pass sets tready once and then waits on falling edges
  // before the next, so tready never gets two updates in one step.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end else begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(1, 16)) @(negedge clk);
        end
      end
    end
  end

  // One pixel word. Called at a falling edge; returns at the falling edge
  // after acceptance with tvalid still high, so back-to-back words keep it up.
  task automatic send_pixel(input logic [7:0] p);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    pix_count++;
  endtask

  // Stop sending and wait until every expected result word is out, plus
  // the block's latency, so a register write lands while it is idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // Register write; ends on the falling edge after lowering cfg_valid.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    // track the saturated geometry to know how many pixels make a frame
    if (idx == REG_WIDTH) begin
      raw_w = val;
      cur_w = (val < 2) ? 2 : (val > MAX_WIDTH) ? MAX_WIDTH : int'(val);
    end
    if (idx == REG_HEIGHT)
      cur_h = (val[FH_W-1:0] < 1) ? 1 :
              (val[FH_W-1:0] > MAX_HEIGHT) ? MAX_HEIGHT : int'(val[FH_W-1:0]);
  endtask

  // One frame at the current geometry. cut_at stops before that pixel
  // (frame left open); thr_at rewrites the threshold before that pixel.
  task automatic send_frame(input frame_style_e style, input int cut_at, input int thr_at);
    int r, c, n, mc;
    logic [7:0] p, lvl_a, lvl_b, base;
    bit row_break, stop;
    lvl_a = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    lvl_b = ($urandom_range(0, 2) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
    base  = 8'($urandom_range(0, 255));
    n     = 0;
    stop  = 1'b0;
    for (r = 0; r < cur_h && !stop; r++) begin
      row_break = ($urandom_range(0, 3) == 0);
      for (c = 0; c < cur_w && !stop; c++) begin
        if (n == cut_at) begin
          stop = 1'b1;
        end else begin
          if (n == thr_at) begin
            settle();
            write_reg(REG_THRESH, CDATA_W'($urandom_range(0, 1023)));
          end
          mc = cur_w - 1 - c;
          case (style)
            STY_NOISE:  p = 8'($urandom_range(0, 255));
            STY_LEVELS: p = $urandom_range(0, 1) ? lvl_a : lvl_b;
            STY_MIRROR: begin
              if (mc < c)
                p = (row_break && c == cur_w - 1) ? ~row_pix[mc] : row_pix[mc];
              else
                p = $urandom_range(0, 1) ? lvl_a : lvl_b;
            end
            default:    p = ($urandom_range(0, 15) == 0) ? base ^ 8'h80 : base;
          endcase
          row_pix[c] = p;
          send_pixel(p);
          n++;
        end
      end
    end
    if (!stop) frames_done++;
  endtask

  initial begin
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_WIDTH;
    cfg_data      = '0;
    repeat (RST_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // a few pixels at reset geometry, then a height write restarts the frame;
    // one row at reset width and reset threshold follows
    repeat (5) send_pixel(8'($urandom_range(0, 255)));
    settle();
    write_reg(REG_HEIGHT, 1);
    send_frame(STY_NOISE, -1, -1);

    // width below range saturates to 2; extremes side by side
    settle();
    write_reg(REG_WIDTH, 0);
    send_pixel(8'd0);
    send_pixel(8'd255);

    // threshold above its field keeps only the low byte: no contrast at 255
    settle();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_THRESH, 10'h3FF);
    send_pixel(8'd255);
    send_pixel(8'd0);

    // height zero saturates to 1; threshold zero with a flat mirrored row
    settle();
    write_reg(REG_HEIGHT, 0);
    write_reg(REG_THRESH, 0);
    send_pixel(8'd7);
    send_pixel(8'd7);

    // odd width, threshold changed in the middle of the frame, unused index
    settle();
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    write_reg(REG_UNUSED, 10'h3FF);
    send_frame(STY_LEVELS, -1, 3);

    // open frame dropped by a size write, then a clean mirrored frame
    send_frame(STY_NOISE, 4, -1);
    settle();
    write_reg(REG_HEIGHT, 2);
    send_frame(STY_MIRROR, -1, -1);

    // sink stalls long while tiny frames keep coming: input must back up
    settle();
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 1);
    quiet = 1'b1;
    long_stall_req = 1'b1;
    wait (!long_stall_req);
    repeat (4) send_frame(STY_NOISE, -1, -1);
    quiet = 1'b0;

    // widest row: width field all ones saturates to the maximum
    settle();
    write_reg(REG_WIDTH, 10'h3FF);
    write_reg(REG_HEIGHT, 1);
    write_reg(REG_THRESH, 254);
    send_frame(STY_MIRROR, -1, -1);

    // tallest frame of one value: longest possible vertical run
    settle();
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 10'h1FF);
    for (j = 0; j < 2 * MAX_HEIGHT; j++) send_pixel(8'd200);
    frames_done++;

    // ---- random part ----
    pix_start    = pix_count;
    frames_start = frames_done;
    while ((pix_count - pix_start) < RAND_PIXELS ||
           (frames_done - frames_start) < RAND_FRAMES) begin
      settle();
      quiet    = ($urandom_range(0, 5) == 0);
      n_frames = $urandom_range(1, 4);
      sel      = $urandom_range(0, 99);
      if (sel < 70) begin
        wv = 10'($urandom_range(2, 12));
        hv = 10'($urandom_range(1, 6));
      end else if (sel < 82) begin
        wv = 10'($urandom_range(0, 1));
        hv = 10'($urandom_range(0, 4));
      end else if (sel < 96) begin
        wv = 10'($urandom_range(13, 64));
        hv = 10'($urandom_range(1, 3));
      end else if (sel < 98) begin
        wv = ($urandom_range(0, 1) != 0) ? 10'd512 : 10'($urandom_range(513, 1023));
        hv = 10'($urandom_range(1, 2));
        n_frames = 1;
      end else begin
        wv = 10'($urandom_range(2, 3));
        hv = 10'($urandom_range(200, 511));
        n_frames = 1;
      end
      // bit 9 of the data word is outside the height field
      hv[9] = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 3);
      tv  = (sel == 0) ? 10'd0 : (sel == 1) ? 10'd255 :
            (sel == 2) ? 10'($urandom_range(0, 40)) : 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_WIDTH, wv);
        write_reg(REG_HEIGHT, hv);
      end else begin
        write_reg(REG_HEIGHT, hv);
        write_reg(REG_WIDTH, wv);
      end
      if ($urandom_range(0, 1) != 0) write_reg(REG_THRESH, tv);
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, CDATA_W'($urandom_range(0, 1023)));
      if ($urandom_range(0, 9) == 0) long_stall_req = 1'b1;
      for (f = 0; f < n_frames; f++) begin
        sty = frame_style_e'($urandom_range(0, 3));
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, cur_w * cur_h - 1) : -1;
        thr = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cur_w * cur_h - 1) : -1;
        send_frame(sty, cut, thr);
        if (cut >= 0) begin
          // drop the open frame by rewriting the same width
          settle();
          write_reg(REG_WIDTH, raw_w);
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ifs_pkg.sv
hw/rtl/ifs_ram.sv
hw/rtl/ifs_cfg.sv
hw/rtl/image_frame_statistics.sv
sim/frame_stats_checker.sv
sim/tb_image_frame_statistics.sv
